// ===== rtl/bmp_rgb565_stream_decoder_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef BMP_RGB565_STREAM_DECODER_MACROS_SVH
`define BMP_RGB565_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define BMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BMP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);
`else
`define BMP_ASSERT(lbl, prop, msg)
`define BMP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/bmp_dec_pkg.sv =====
`timescale 1ns / 1ps
package bmp_dec_pkg;

    localparam int MAX_SIDE_DEF = 128;

    localparam int HDR_LEN = 54;
    localparam int HDR_W   = 6;

    // byte offsets of the header fields
    localparam int OFF_SIG    = 0;
    localparam int OFF_DATA   = 10;
    localparam int OFF_INFO   = 14;
    localparam int OFF_WIDTH  = 18;
    localparam int OFF_HEIGHT = 22;
    localparam int OFF_BPP    = 28;
    localparam int OFF_COMP   = 30;

    localparam logic [15:0] SIG_BM         = 16'h4D42;
    localparam logic [31:0] INFO_MIN       = 32'd40;
    localparam logic [15:0] BPP_RGB565     = 16'd16;
    localparam logic [31:0] COMP_BITFIELDS = 32'd3;

    localparam int CAP_W = 15;
    localparam logic [CAP_W-1:0] CAP_RESET = 15'd16384;

    localparam int IDX_W    = 14;
    localparam int TDATA_W  = 56;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_SIG      = 4'd2;
    localparam logic [3:0] ST_INFO     = 4'd3;
    localparam logic [3:0] ST_DIMS     = 4'd4;
    localparam logic [3:0] ST_DEPTH    = 4'd5;
    localparam logic [3:0] ST_COMP     = 4'd6;
    localparam logic [3:0] ST_CAP      = 4'd7;
    localparam logic [3:0] ST_DATA     = 4'd8;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [15:0]      value;
        logic [3:0]       status;
        logic [7:0]       width;
        logic [7:0]       height;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } step_t;

endpackage

// ===== rtl/bmp_dec_core.sv =====
`timescale 1ns / 1ps
`include "bmp_rgb565_stream_decoder_macros.svh"
module bmp_dec_core import bmp_dec_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic             in_kind,
    input  logic [7:0]       in_byte,
    input  logic [CAP_W-1:0] capacity,
    output step_t            step
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AREA_W = 2 * SIDE_W;
    localparam int LIN_W  = POS_W + SIDE_W;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SEEK   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [31:0]      fpos_reg, fpos_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [1:0]       pad_reg, pad_next;
    logic             half_reg, half_next;
    logic [7:0]       hold_reg, hold_next;

    logic [15:0] sig_reg;
    logic [31:0] off_reg;
    logic [31:0] info_reg;
    logic [31:0] w_reg;
    logic [31:0] h_reg;
    logic [15:0] bpp_reg;
    logic [31:0] comp_reg;

    logic [SIDE_W-1:0] w_side, h_side, col_inc;
    logic [AREA_W-1:0] area;
    logic [LIN_W-1:0]  lin;
    logic [31:0]       fpos_inc;
    logic [7:0]        w8, h8;
    logic              dims_ok;
    logic [3:0]        hdr_status;

    logic       rep_en, rep_dims, pix_en, row_end;
    logic [3:0] rep_st;
    result_t    rep_res, pix_res;

    assign w_side   = w_reg[SIDE_W-1:0];
    assign h_side   = h_reg[SIDE_W-1:0];
    assign w8       = 8'(w_side);
    assign h8       = 8'(h_side);
    assign dims_ok  = (w_reg != '0) && (w_reg <= 32'(MAX_SIDE))
                   && (h_reg != '0) && (h_reg <= 32'(MAX_SIDE));
    assign area     = AREA_W'(w_side) * AREA_W'(h_side);
    assign lin      = LIN_W'(row_reg) * LIN_W'(w_side) + LIN_W'(col_reg);
    assign col_inc  = SIDE_W'(col_reg) + SIDE_W'(1);
    assign fpos_inc = fpos_reg + 32'd1;

    always_comb begin
        if (sig_reg != SIG_BM) begin
            hdr_status = ST_SIG;
        end else if (info_reg < INFO_MIN) begin
            hdr_status = ST_INFO;
        end else if (!dims_ok) begin
            hdr_status = ST_DIMS;
        end else if (bpp_reg != BPP_RGB565) begin
            hdr_status = ST_DEPTH;
        end else if (comp_reg != COMP_BITFIELDS) begin
            hdr_status = ST_COMP;
        end else if (32'(area) > 32'(capacity)) begin
            hdr_status = ST_CAP;
        end else begin
            hdr_status = ST_OK;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        fpos_next  = fpos_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pad_next   = pad_reg;
        half_next  = half_reg;
        hold_next  = hold_reg;
        rep_en     = 1'b0;
        rep_st     = ST_OK;
        rep_dims   = 1'b0;
        pix_en     = 1'b0;
        row_end    = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (in_kind) begin
                    rep_en = 1'b1;
                    rep_st = ST_SHORT;
                end else begin
                    fpos_next = fpos_inc;
                    if (fpos_reg == 32'(HDR_LEN - 1)) begin
                        if (hdr_status != ST_OK) begin
                            rep_en   = 1'b1;
                            rep_st   = hdr_status;
                            rep_dims = (hdr_status >= ST_DEPTH);
                        end else begin
                            row_next  = POS_W'(h_side - SIDE_W'(1));
                            col_next  = '0;
                            pad_next  = 2'd0;
                            half_next = 1'b0;
                            if (off_reg < 32'(HDR_LEN)) begin
                                rep_en   = 1'b1;
                                rep_st   = ST_DATA;
                                rep_dims = 1'b1;
                            end else if (off_reg == 32'(HDR_LEN)) begin
                                phase_next = PH_PIXELS;
                            end else begin
                                phase_next = PH_SEEK;
                            end
                        end
                    end
                end
            end
            PH_SEEK: begin
                if (in_kind) begin
                    rep_en   = 1'b1;
                    rep_st   = ST_DATA;
                    rep_dims = 1'b1;
                end else begin
                    fpos_next = fpos_inc;
                    if (fpos_inc == off_reg) begin
                        phase_next = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS: begin
                if (in_kind) begin
                    rep_en   = 1'b1;
                    rep_st   = ST_DATA;
                    rep_dims = 1'b1;
                end else if (pad_reg != 2'd0) begin
                    pad_next = pad_reg - 2'd1;
                    row_end  = (pad_reg == 2'd1);
                end else if (!half_reg) begin
                    hold_next = in_byte;
                    half_next = 1'b1;
                end else begin
                    half_next = 1'b0;
                    pix_en    = 1'b1;
                    if (col_inc == w_side) begin
                        col_next = '0;
                        pad_next = w_side[0] ? 2'd2 : 2'd0;
                        row_end  = !w_side[0];
                    end else begin
                        col_next = POS_W'(col_inc);
                    end
                end
            end
            PH_DONE: begin
            end
        endcase

        // end of a row, the top one closes the run
        if (row_end) begin
            if (row_reg == '0) begin
                rep_en   = 1'b1;
                rep_st   = ST_OK;
                rep_dims = 1'b1;
            end else begin
                row_next = row_reg - POS_W'(1);
            end
        end
        if (rep_en) begin
            phase_next = PH_DONE;
        end
    end

    always_comb begin
        rep_res        = '0;
        rep_res.kind   = 1'b1;
        rep_res.status = rep_st;
        rep_res.width  = rep_dims ? w8 : 8'd0;
        rep_res.height = rep_dims ? h8 : 8'd0;

        pix_res        = '0;
        pix_res.index  = IDX_W'(lin);
        pix_res.value  = {in_byte, hold_reg};

        step = '0;
        if (pix_en && rep_en) begin
            step.cnt = 2'd2;
            step.r0  = pix_res;
            step.r1  = rep_res;
            step.r1.last = 1'b1;
        end else if (pix_en) begin
            step.cnt = 2'd1;
            step.r0  = pix_res;
            step.r0.last = 1'b1;
        end else if (rep_en) begin
            step.cnt = 2'd1;
            step.r0  = rep_res;
            step.r0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            fpos_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            pad_reg   <= 2'd0;
            half_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            fpos_reg  <= fpos_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pad_reg   <= pad_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            hold_reg <= hold_next;
        end
    end

    // little-endian fields shift in from the top
    always_ff @(posedge aclk) begin
        if (step_en && (phase_reg == PH_HEADER) && !in_kind) begin
            case (fpos_reg[HDR_W-1:0]) inside
                [OFF_SIG:OFF_SIG+1]:       sig_reg  <= {in_byte, sig_reg[15:8]};
                [OFF_DATA:OFF_DATA+3]:     off_reg  <= {in_byte, off_reg[31:8]};
                [OFF_INFO:OFF_INFO+3]:     info_reg <= {in_byte, info_reg[31:8]};
                [OFF_WIDTH:OFF_WIDTH+3]:   w_reg    <= {in_byte, w_reg[31:8]};
                [OFF_HEIGHT:OFF_HEIGHT+3]: h_reg    <= {in_byte, h_reg[31:8]};
                [OFF_BPP:OFF_BPP+1]:       bpp_reg  <= {in_byte, bpp_reg[15:8]};
                [OFF_COMP:OFF_COMP+3]:     comp_reg <= {in_byte, comp_reg[31:8]};
                default: begin
                end
            endcase
        end
    end

    `BMP_ASSERT_NEXT(a_done_sticky, phase_reg == PH_DONE, phase_reg == PH_DONE, "run restarted without reset")
    `BMP_ASSERT(a_pair_order, (step.cnt == 2'd2) |-> (!step.r0.kind && step.r1.kind), "two results must be pixel then report")

endmodule

// ===== rtl/bmp_dec_outq.sv =====
`timescale 1ns / 1ps
`include "bmp_rgb565_stream_decoder_macros.svh"
module bmp_dec_outq import bmp_dec_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  step_t      push,
    output logic [1:0] occupancy,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    result_t    slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid   = (cnt_reg != 2'd0);
    assign pop         = out_valid && out_ready;
    assign head        = slot_reg[rd_ptr_reg];
    assign occupancy   = cnt_reg;
    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign wr_ptr_next = wr_ptr_reg ^ push.cnt[0];
    assign cnt_next    = cnt_reg + push.cnt - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            slot_reg[!wr_ptr_reg] <= push.r1;
        end
    end

    `BMP_ASSERT(a_cnt_range, cnt_reg != 2'd3, "result queue overfilled")
    `BMP_ASSERT(a_pair_into_empty, (push.cnt == 2'd2) |-> (cnt_reg == 2'd0), "two results pushed into a busy queue")

endmodule

// ===== rtl/bmp_rgb565_stream_decoder.sv =====
`timescale 1ns / 1ps
`include "bmp_rgb565_stream_decoder_macros.svh"
// a byte accepted is held in the input register, then any result it gives is written to the output queue
// throughput: one byte per cycle, sustained while m_tready stays high
// the step that ends the last unpadded row gives a pixel and the report together
// reset: synchronous on aresetn, clears control state, capacity back to 16384
// after the final report every byte and end mark is taken and dropped until reset
module bmp_rgb565_stream_decoder import bmp_dec_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tuser,   // kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // pixel_index, pixel_value, status,
                                          // image_width, image_height, zero fill
    output logic               m_tuser,   // result_kind
    output logic               m_tlast,   // last_of_run
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data   // pixel_capacity
);

    logic             in_vld_reg, in_vld_next;
    logic             in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic [CAP_W-1:0] cap_reg;
    logic             fire;
    logic [1:0]       q_occ;
    step_t            core_step, q_push;
    result_t          q_head;

    assign cfg_ready   = 1'b1;
    assign fire        = in_vld_reg && (({1'b0, q_occ} + {1'b0, core_step.cnt}) <= 3'd2);
    assign s_tready    = !in_vld_reg || fire;
    assign in_vld_next = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    assign q_push      = fire ? core_step : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cap_reg    <= CAP_RESET;
        end else begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    bmp_dec_core #(
        .MAX_SIDE(MAX_SIDE)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (fire),
        .in_kind  (in_kind_reg),
        .in_byte  (in_byte_reg),
        .capacity (cap_reg),
        .step     (core_step)
    );

    bmp_dec_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .occupancy (q_occ),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (q_head)
    );

    assign m_tuser = q_head.kind;
    assign m_tlast = q_head.last;
    assign m_tdata = {6'd0, q_head.height, q_head.width, q_head.status,
                      q_head.value, q_head.index};

    `BMP_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, in_vld_reg, "accepted request not held")

endmodule

// ===== test/bmp_rgb565_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
module bmp_rgb565_stream_decoder_tb;
    import bmp_dec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {PH_CAPTURE, PH_SKIP, PH_PIXELS, PH_DONE} dec_phase_e;

    typedef enum int {
        F_NONE, F_SIG, F_OFFSET, F_INFO, F_WIDTH, F_HEIGHT, F_DEPTH, F_COMP, F_CAP, F_SHORT
    } header_fault_e;

    typedef struct {
        int          at;
        int          size;
        logic [31:0] good;
        logic [31:0] bad;
        logic [3:0]  status;
    } header_field_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data = '0;

    // decoder model state
    dec_phase_e       dec_phase = PH_CAPTURE;
    logic [7:0]       hdr_bytes [HDR_LEN];
    int unsigned      byte_pos = 0;
    int unsigned      cur_col = 0;
    int unsigned      cur_row = 0;
    int unsigned      pad_left = 0;
    logic [7:0]       low_hold = '0;
    bit               high_next = 1'b0;
    logic [CAP_W-1:0] capacity = CAP_RESET;

    result_t     pending_results [$];
    result_t     typed_report;
    bit          typed_pending = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned send_idle = 0;
    int unsigned stall_pct = 0;
    int unsigned send_idle_by_phase [4] = '{0, 79, 0, 31};
    int unsigned stall_by_phase [4] = '{0, 0, 79, 31};

    header_field_t hdr_fields [F_SIG:F_COMP];

    bmp_rgb565_stream_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] hdr_word(input int at);
        return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    function automatic result_t final_report(input logic [3:0] st, input logic with_dims);
        result_t     r;
        logic [31:0] w;
        logic [31:0] h;
        w = hdr_word(OFF_WIDTH);
        h = hdr_word(OFF_HEIGHT);
        r = '0;
        r.kind = 1'b1;
        r.status = st;
        if (with_dims) begin
            r.width = w[7:0];
            r.height = h[7:0];
        end
        dec_phase = PH_DONE;
        return r;
    endfunction

    function automatic logic [3:0] header_verdict();
        logic [31:0] w;
        logic [31:0] h;
        w = hdr_word(OFF_WIDTH);
        h = hdr_word(OFF_HEIGHT);
        if ({hdr_bytes[OFF_SIG+1], hdr_bytes[OFF_SIG]} != SIG_BM) return ST_SIG;
        if (hdr_word(OFF_INFO) < INFO_MIN) return ST_INFO;
        if (w == 0 || w > MAX_SIDE_DEF || h == 0 || h > MAX_SIDE_DEF) return ST_DIMS;
        if ({hdr_bytes[OFF_BPP+1], hdr_bytes[OFF_BPP]} != BPP_RGB565) return ST_DEPTH;
        if (hdr_word(OFF_COMP) != COMP_BITFIELDS) return ST_COMP;
        if (w * h > {17'd0, capacity}) return ST_CAP;
        return ST_OK;
    endfunction

    // rows arrive bottom-up, the top row closes the image
    task automatic close_row(inout result_t outs [2], inout int n);
        if (cur_row == 0) begin
            outs[n] = final_report(ST_OK, 1'b1);
            n++;
        end else begin
            cur_row--;
        end
    endtask

    task automatic decode_byte(input logic kind, input logic [7:0] b,
                               output result_t outs [2], output int n);
        logic [31:0] w;
        logic [31:0] offset;
        logic [31:0] pix_at;
        logic [3:0]  verdict;
        n = 0;
        outs[0] = '0;
        outs[1] = '0;
        if (dec_phase == PH_DONE) return;
        if (kind) begin
            outs[0] = final_report(dec_phase == PH_CAPTURE ? ST_SHORT : ST_DATA,
                                   dec_phase != PH_CAPTURE);
            n = 1;
        end else begin
            case (dec_phase)
                PH_CAPTURE: begin
                    hdr_bytes[byte_pos] = b;
                    byte_pos++;
                    if (byte_pos == HDR_LEN) begin
                        verdict = header_verdict();
                        offset = hdr_word(OFF_DATA);
                        if (verdict != ST_OK) begin
                            outs[0] = final_report(verdict, verdict >= ST_DEPTH);
                            n = 1;
                        end else begin
                            cur_row = hdr_word(OFF_HEIGHT) - 1;
                            cur_col = 0;
                            pad_left = 0;
                            high_next = 1'b0;
                            if (offset < HDR_LEN) begin
                                outs[0] = final_report(ST_DATA, 1'b1);
                                n = 1;
                            end else if (offset == HDR_LEN) begin
                                dec_phase = PH_PIXELS;
                            end else begin
                                dec_phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    byte_pos++;
                    if (byte_pos == hdr_word(OFF_DATA)) dec_phase = PH_PIXELS;
                end
                default: begin
                    w = hdr_word(OFF_WIDTH);
                    if (pad_left != 0) begin
                        pad_left--;
                        if (pad_left == 0) close_row(outs, n);
                    end else if (!high_next) begin
                        low_hold = b;
                        high_next = 1'b1;
                    end else begin
                        high_next = 1'b0;
                        pix_at = cur_row * w + cur_col;
                        outs[0].index = pix_at[IDX_W-1:0];
                        outs[0].value = {b, low_hold};
                        n = 1;
                        cur_col++;
                        if (cur_col >= w) begin
                            cur_col = 0;
                            pad_left = (4 - ((w * 2) & 3)) & 3;
                            if (pad_left == 0) close_row(outs, n);
                        end
                    end
                end
            endcase
        end
        if (n > 0) outs[n-1].last = 1'b1;
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        capacity = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input logic kind, input logic [7:0] data);
        result_t outs [2];
        int      n;
        send_idle = send_idle_by_phase[(items_sent / 100) % 4];
        stall_pct = stall_by_phase[(items_sent / 100) % 4];
        items_sent++;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        decode_byte(kind, data, outs, n);
        if (typed_pending && n != 0) begin
            pending_results.push_back(typed_report);
            typed_pending = 1'b0;
        end else begin
            for (int i = 0; i < n; i++) pending_results.push_back(outs[i]);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.index = m_tdata[IDX_W-1:0];
            got.value = m_tdata[IDX_W +: 16];
            got.status = m_tdata[IDX_W+16 +: 4];
            got.width = m_tdata[IDX_W+20 +: 8];
            got.height = m_tdata[IDX_W+28 +: 8];
            got.last = m_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d index %0d status %0d",
                         $time, got.kind, got.index, got.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("pixel_index", want.index, got.index);
                check_field("pixel_value", want.value, got.value);
                check_field("status", want.status, got.status);
                check_field("image_width", want.width, got.width);
                check_field("image_height", want.height, got.height);
                check_field("last_of_run", want.last, got.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        header_fault_e    fault;
        logic [7:0]       hdr_img [HDR_LEN];
        logic [31:0]      fval;
        logic [3:0]       typed_st;
        logic [CAP_W-1:0] cap;
        int unsigned      w_px;
        int unsigned      h_px;
        int unsigned      skip;
        int unsigned      row_bytes;
        int unsigned      body;
        int unsigned      cut_at;
        int unsigned      short_at;

        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        fault = ($urandom_range(0, 99) < 70) ? F_NONE
                                             : header_fault_e'($urandom_range(F_SIG, F_SHORT));
        case ($urandom_range(0, 7))
            0: begin
                w_px = MAX_SIDE_DEF;
                h_px = $urandom_range(1, 4);
            end
            1: begin
                w_px = $urandom_range(1, 4);
                h_px = MAX_SIDE_DEF;
            end
            default: begin
                w_px = $urandom_range(1, 40);
                row_bytes = w_px * 2 + ((w_px % 2) ? 2 : 0);
                h_px = 1300 / row_bytes;
                if (h_px > MAX_SIDE_DEF) h_px = MAX_SIDE_DEF;
                if (h_px == 0) h_px = 1;
            end
        endcase
        row_bytes = w_px * 2 + ((w_px % 2) ? 2 : 0);
        skip = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);

        // checked header fields: good value, broken value, status the broken one gives
        hdr_fields[F_SIG]    = '{OFF_SIG, 2, {16'd0, SIG_BM}, 32'h0000_424D, ST_SIG};
        hdr_fields[F_OFFSET] = '{OFF_DATA, 4, HDR_LEN + skip, 32'd53, ST_DATA};
        hdr_fields[F_INFO]   = '{OFF_INFO, 4, $urandom_range(0, 1) ? INFO_MIN : 32'hFFFF_FFFF,
                                 32'd39, ST_INFO};
        hdr_fields[F_WIDTH]  = '{OFF_WIDTH, 4, w_px, 32'd0, ST_DIMS};
        hdr_fields[F_HEIGHT] = '{OFF_HEIGHT, 4, h_px, 32'hFFFF_FF80, ST_DIMS};
        hdr_fields[F_DEPTH]  = '{OFF_BPP, 2, {16'd0, BPP_RGB565}, 32'd24, ST_DEPTH};
        hdr_fields[F_COMP]   = '{OFF_COMP, 4, COMP_BITFIELDS, 32'd0, ST_COMP};

        foreach (hdr_img[i]) hdr_img[i] = $urandom_range(0, 255);
        for (int f = F_SIG; f <= F_COMP; f++) begin
            fval = (fault == f) ? hdr_fields[f].bad : hdr_fields[f].good;
            for (int k = 0; k < hdr_fields[f].size; k++)
                hdr_img[hdr_fields[f].at + k] = fval[8*k +: 8];
        end

        if (fault != F_NONE) begin
            if (fault == F_CAP) typed_st = ST_CAP;
            else if (fault == F_SHORT) typed_st = ST_SHORT;
            else typed_st = hdr_fields[fault].status;
            typed_report = '0;
            typed_report.kind = 1'b1;
            typed_report.status = typed_st;
            typed_report.last = 1'b1;
            if (typed_st >= ST_DEPTH) begin
                typed_report.width = w_px[7:0];
                typed_report.height = h_px[7:0];
            end
            typed_pending = 1'b1;
        end

        if (fault == F_CAP) begin
            cap = $urandom_range(0, 1) ? '0 : CAP_W'(w_px * h_px - 1);
        end else begin
            case ($urandom_range(0, 3))
                0: cap = CAP_RESET;
                1: cap = '1;
                2: cap = CAP_W'(w_px * h_px);
                default: cap = CAP_W'($urandom_range(w_px * h_px, CAP_RESET));
            endcase
        end
        write_capacity('0);
        write_capacity('1);
        write_capacity(cap);

        short_at = (fault == F_SHORT) ? $urandom_range(0, HDR_LEN - 1) : HDR_LEN;
        for (int i = 0; i < HDR_LEN; i++) begin
            if (i == short_at) begin
                send_item(1'b1, $urandom_range(0, 255));
                break;
            end
            send_item(1'b0, hdr_img[i]);
        end

        if (fault == F_NONE) begin
            body = skip + row_bytes * h_px;
            cut_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, body - 1) : body;
            for (int i = 0; i < body; i++) begin
                if (i == cut_at) begin
                    send_item(1'b1, $urandom_range(0, 255));
                    break;
                end
                send_item(1'b0, $urandom_range(0, 255));
            end
        end

        // trailing input after the report is dropped
        repeat ($urandom_range(4, 12)) send_item($urandom_range(0, 3) == 0, $urandom_range(0, 255));
        send_item(1'b1, $urandom_range(0, 255));
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
